// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

    // Default sizes
    localparam int VALUE_BITS_DEF        = 31;
    localparam int DIGIT_STORE_DEPTH_DEF = 32;

    // Stream and register port widths
    localparam int OUT_TDATA_W = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;

    // Radix register
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic               REG_RADIX   = 1'b0;   // word index bit paddr[2]

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd65;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LOAD
    } t_state;

    // Divider control from the sequencer
    typedef struct packed {
        logic load;     // take a new dividend and start
        logic start;    // divide the held quotient again
    } t_div_ctrl;

    // Divider status back to the sequencer
    typedef struct packed {
        logic               done;       // one-cycle pulse, quotient and rem valid
        logic               q_nonzero;  // quotient of the last pass is not zero
        logic [DIGIT_W-1:0] rem;
    } t_div_stat;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + ext;
        end else begin
            return CHAR_LETTER + ext - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
        end
    endfunction

endpackage

// ===== rtl/rdc_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, dividend shifts
// out the top while quotient bits shift in at the bottom.
module rdc_divider #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rdc_pkg::t_div_ctrl            i_ctrl,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic [rdc_pkg::RADIX_W-1:0]   i_radix,
    output rdc_pkg::t_div_stat            o_stat
);

    localparam int CW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0]       r_q;
    logic [rdc_pkg::DIGIT_W-1:0] r_rem;
    logic                        r_qnz;
    logic [CW-1:0]               r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [rdc_pkg::RADIX_W-1:0] w_shift;
    logic [rdc_pkg::RADIX_W-1:0] w_diff;
    logic                        w_ge;

    // Partial remainder with the next dividend bit, trial subtract
    always_comb begin
        w_shift = {r_rem, r_q[VALUE_BITS-1]};
        w_ge    = (w_shift >= i_radix);
        w_diff  = w_shift - i_radix;
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.load || i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath shift
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load || i_ctrl.start) begin
            if (i_ctrl.load) begin
                r_q <= i_value;
            end
            r_rem <= '0;
            r_qnz <= 1'b0;
        end else if (r_busy) begin
            r_q   <= {r_q[VALUE_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[rdc_pkg::DIGIT_W-1:0] : w_shift[rdc_pkg::DIGIT_W-1:0];
            r_qnz <= r_qnz | w_ge;
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.q_nonzero = r_qnz;
    assign o_stat.rem       = r_rem;

endmodule

// ===== rtl/rdc_digit_store.sv =====
// Remainder store: one write port, one registered read port.
module rdc_digit_store #(
    parameter int DEPTH = rdc_pkg::DIGIT_STORE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [rdc_pkg::DIGIT_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [rdc_pkg::DIGIT_W-1:0] o_rd_data
);

    logic [rdc_pkg::DIGIT_W-1:0] r_mem [DEPTH];
    logic [rdc_pkg::DIGIT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/radix_digit_converter_core.sv =====
// Each digit is one full pass of the bit-serial divider. When the quotient is
// zero or the store is full, the digits are read back from the store and leave
// one at a time, most significant first; a new item is taken only after the
// last digit has been loaded into the output register.
// Reset (synchronous, active low) returns to idle, drops any pending digit and
// sets the radix to 10. The digit store is not cleared.
module radix_digit_converter_core #(
    parameter int VALUE_BITS        = rdc_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_STORE_DEPTH = rdc_pkg::DIGIT_STORE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]   i_s_tdata,    // [VALUE_BITS-1:0] value
    // Output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rdc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,    // [6:0] digit_char, [10:7] digit_value
    output logic                              o_m_tlast,    // last_digit
    // Register port
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [rdc_pkg::PADDR_W-1:0]       i_paddr,
    input  logic [rdc_pkg::PDATA_W-1:0]       i_pwdata,
    output logic [rdc_pkg::PDATA_W-1:0]       o_prdata,
    output logic                              o_pready
);

    localparam int AW    = $clog2(DIGIT_STORE_DEPTH);
    localparam int CNT_W = $clog2(DIGIT_STORE_DEPTH + 1);

    rdc_pkg::t_state             r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [AW-1:0]               r_ptr, n_ptr;
    logic [rdc_pkg::RADIX_W-1:0] r_radix;

    logic                        r_out_valid;
    logic [rdc_pkg::DIGIT_W-1:0] r_out_digit;
    logic [rdc_pkg::CHAR_W-1:0]  r_out_char;
    logic                        r_out_last;

    rdc_pkg::t_div_ctrl          w_div_ctrl;
    rdc_pkg::t_div_stat          w_div_stat;
    logic                        w_s_ready;
    logic                        w_wr_en;
    logic                        w_rd_en;
    logic                        w_out_load;
    logic [rdc_pkg::DIGIT_W-1:0] w_rd_data;
    logic [rdc_pkg::RADIX_W-1:0] w_wr_radix;
    logic                        w_cfg_wr;

    // Register port: radix, clamped on write
    assign w_wr_radix = i_pwdata[rdc_pkg::RADIX_W-1:0];
    assign w_cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr[2] == rdc_pkg::REG_RADIX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rdc_pkg::RADIX_RESET;
        end else if (w_cfg_wr) begin
            if (w_wr_radix < rdc_pkg::RADIX_MIN) begin
                r_radix <= rdc_pkg::RADIX_MIN;
            end else if (w_wr_radix > rdc_pkg::RADIX_MAX) begin
                r_radix <= rdc_pkg::RADIX_MAX;
            end else begin
                r_radix <= w_wr_radix;
            end
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == rdc_pkg::REG_RADIX)
                    ? {{(rdc_pkg::PDATA_W-rdc_pkg::RADIX_W){1'b0}}, r_radix}
                    : '0;

    // Divider and store
    rdc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .i_value (i_s_tdata[VALUE_BITS-1:0]),
        .i_radix (r_radix),
        .o_stat  (w_div_stat)
    );

    rdc_digit_store #(
        .DEPTH (DIGIT_STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_div_stat.rem),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::ST_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    // Sequencer: divide until the quotient is zero or the store is full, then read digits back
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        w_div_ctrl = '0;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        w_out_load = 1'b0;
        w_s_ready  = 1'b0;
        case (r_state)
            rdc_pkg::ST_IDLE: begin
                w_s_ready = 1'b1;
                if (i_s_tvalid) begin
                    w_div_ctrl.load = 1'b1;
                    n_count         = '0;
                    n_state         = rdc_pkg::ST_DIVIDE;
                end
            end
            rdc_pkg::ST_DIVIDE: begin
                if (w_div_stat.done) begin
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                    if (!w_div_stat.q_nonzero ||
                        r_count == CNT_W'(DIGIT_STORE_DEPTH - 1)) begin
                        n_ptr   = r_count[AW-1:0];
                        n_state = rdc_pkg::ST_READ;
                    end else begin
                        w_div_ctrl.start = 1'b1;
                    end
                end
            end
            rdc_pkg::ST_READ: begin
                w_rd_en = 1'b1;
                n_state = rdc_pkg::ST_LOAD;
            end
            rdc_pkg::ST_LOAD: begin
                if (!r_out_valid || i_m_tready) begin
                    w_out_load = 1'b1;
                    if (r_ptr == '0) begin
                        n_state = rdc_pkg::ST_IDLE;
                    end else begin
                        n_ptr   = r_ptr - 1'b1;
                        n_state = rdc_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    // No item is taken while reset is held
    assign o_s_tready = w_s_ready && i_rst_n;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_digit <= w_rd_data;
            r_out_char  <= rdc_pkg::digit_to_char(w_rd_data);
            r_out_last  <= (r_ptr == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(rdc_pkg::OUT_TDATA_W-rdc_pkg::DIGIT_W-rdc_pkg::CHAR_W){1'b0}},
                         r_out_digit, r_out_char};

`ifndef SYNTH
    // Stored radix is always a legal base
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_radix >= rdc_pkg::RADIX_MIN && r_radix <= rdc_pkg::RADIX_MAX)
        else $error("radix register out of range");

    // A taken item always starts a division
    a_accept_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_state == rdc_pkg::ST_DIVIDE)
        else $error("accepted item did not start division");

    // Divider finishes only while the sequencer waits for it
    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == rdc_pkg::ST_DIVIDE)
        else $error("divider done outside divide state");

    // Digit count never runs past the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DIGIT_STORE_DEPTH))
        else $error("digit count exceeds store depth");

    // Loading the final digit returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load && r_ptr == '0 |=> r_state == rdc_pkg::ST_IDLE)
        else $error("sequencer not idle after last digit");
`endif

endmodule
